/* rtl/ctbh_pkg.sv */
// Shared types and constants for the cycle timer bank with interrupt hold.
// Used by ctbh_step_unit, ctbh_result_buf and cycle_timer_bank_with_irq_hold.
// No dependencies.
package ctbh_pkg;

  // Bank size and per-transaction result cap
  localparam int NUM_TIMERS  = 8;
  localparam int MAX_RESULTS = 10;

  localparam int SLOT_IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int EMIT_CNT_W = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int OP_W      = 3;
  localparam int KIND_W    = 3;
  localparam int KEY_W     = 32;
  localparam int COUNT_W   = 24;
  localparam int ELAPSED_W = 8;
  localparam int REMAIN_W  = 26;

  // Input opcodes; codes 6 and 7 only return a nothing result
  typedef enum logic [OP_W-1:0] {
    OP_SET_TIMER  = 3'd0,
    OP_ADVANCE    = 3'd1,
    OP_ASSERT_IRQ = 3'd2,
    OP_ASSERT_NMI = 3'd3,
    OP_CLEAR_IRQ  = 3'd4,
    OP_CLEAR_NMI  = 3'd5
  } op_e;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SET_REPLY   = 3'd0,
    KIND_FIRED       = 3'd1,
    KIND_IRQ_RELEASE = 3'd2,
    KIND_NMI_RELEASE = 3'd3,
    KIND_NOTHING     = 3'd4,
    KIND_ACK         = 3'd5
  } kind_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HOLD_IRQ,
    ST_HOLD_NMI,
    ST_SLOT,
    ST_NOTHING,
    ST_FIND,
    ST_CLAIM,
    ST_DONE
  } seq_state_e;

  // One result item, without the last flag
  typedef struct packed {
    kind_e              kind;
    logic [KEY_W-1:0]   fired_key;
    logic               set_ok;
    logic               irq_active;
    logic               nmi_active;
  } result_t;

  // Sequencer to result buffer
  typedef struct packed {
    logic push;
    logic finish;
  } buf_ctl_t;

  // Result buffer to sequencer
  typedef struct packed {
    logic ready;
    logic pending;
  } buf_sts_t;

endpackage

/* rtl/ctbh_step_unit.sv */
// Shared countdown unit: optional reload of a signed count, then subtract
// the elapsed cycles. Serves both hold counters and every timer slot.
// Depends on ctbh_pkg.
module ctbh_step_unit (
  input  logic signed [ctbh_pkg::REMAIN_W-1:0]  base_i,
  input  logic        [ctbh_pkg::COUNT_W-1:0]   reload_i,
  input  logic                                  reload_en_i,
  input  logic        [ctbh_pkg::ELAPSED_W-1:0] elapsed_i,
  output logic signed [ctbh_pkg::REMAIN_W-1:0]  result_o,
  output logic                                  le_zero_o
);
  import ctbh_pkg::*;

  logic signed [REMAIN_W-1:0] reloaded;
  logic                       base_le_zero;

  // Reload by the period when the count has run out
  assign base_le_zero = base_i[REMAIN_W-1] || (base_i == '0);

  always_comb begin
    if (reload_en_i && base_le_zero) begin
      reloaded = base_i + $signed(REMAIN_W'(reload_i));
    end else begin
      reloaded = base_i;
    end
    result_o  = reloaded - $signed(REMAIN_W'(elapsed_i));
    le_zero_o = result_o[REMAIN_W-1] || (result_o == '0);
  end

endmodule

/* rtl/ctbh_result_buf.sv */
// Result buffer: one pending result plus the output register. A result is
// held back until the next one or the end of the transaction decides last.
// Depends on ctbh_pkg.
module ctbh_result_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctbh_pkg::buf_ctl_t  ctl_i,
  input  ctbh_pkg::result_t   res_i,
  output ctbh_pkg::buf_sts_t  sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ctbh_pkg::result_t   out_res_o,
  output logic                out_last_o
);
  import ctbh_pkg::*;

  logic    pend_valid_q;
  result_t pend_res_q;
  logic    out_valid_q;
  result_t out_res_q;
  logic    out_last_q;
  logic    out_free;
  logic    move;

  assign out_free = !out_valid_q || !out_stall_i;
  assign move     = pend_valid_q && (ctl_i.push || ctl_i.finish);

  assign sts_o.ready   = !pend_valid_q || out_free;
  assign sts_o.pending = pend_valid_q;

  // Pending slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (ctl_i.push) begin
      pend_valid_q <= 1'b1;
    end else if (ctl_i.finish) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      pend_res_q <= res_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_res_q  <= pend_res_q;
      out_last_q <= ctl_i.finish;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_last_o  = out_last_q;

endmodule

/* rtl/cycle_timer_bank_with_irq_hold.sv */
// Bank of NUM_TIMERS periodic cycle timers plus IRQ and NMI lines with
// auto-release hold counts. One transaction is worked on at a time by a
// sequencer that walks the hold counters and the timer slots through a
// single shared countdown unit, one counter or slot per cycle unless a
// step waits on the result buffer. An advance steps both hold counters,
// every slot and a no-event check; a set-timer searches the slots for
// its key and else claims the first free slot; assert, clear and unused
// codes reply at once. Results leave through a pending slot and an
// output register, so the next transaction is accepted while the final
// result still waits to be taken. At most MAX_RESULTS results per
// transaction; later events are dropped but the state is still updated.
// Depends on ctbh_pkg, ctbh_step_unit and ctbh_result_buf.
module cycle_timer_bank_with_irq_hold (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ctbh_pkg::OP_W-1:0]          op_i,
  input  logic [ctbh_pkg::KEY_W-1:0]         timer_key_i,
  input  logic [ctbh_pkg::COUNT_W-1:0]       count_value_i,
  input  logic [ctbh_pkg::ELAPSED_W-1:0]     elapsed_cycles_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ctbh_pkg::KIND_W-1:0]        kind_o,
  output logic [ctbh_pkg::KEY_W-1:0]         fired_key_o,
  output logic                               set_ok_o,
  output logic                               irq_active_o,
  output logic                               nmi_active_o,
  output logic                               last_o
);
  import ctbh_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(NUM_TIMERS - 1);

  // Sequencer and latched transaction
  seq_state_e               state_q, state_d;
  logic [OP_W-1:0]          op_q;
  logic [KEY_W-1:0]         key_q;
  logic [COUNT_W-1:0]       cnt_q;
  logic [ELAPSED_W-1:0]     elapsed_q;
  logic [SLOT_IDX_W-1:0]    idx_q, idx_d;
  logic                     free_found_q, free_found_d;
  logic [SLOT_IDX_W-1:0]    free_idx_q, free_idx_d;
  logic [EMIT_CNT_W-1:0]    emit_cnt_q;

  // Interrupt lines
  logic [COUNT_W-1:0]       irq_hold_q, irq_hold_d;
  logic [COUNT_W-1:0]       nmi_hold_q, nmi_hold_d;
  logic                     irq_line_q, irq_line_d;
  logic                     nmi_line_q, nmi_line_d;

  // Timer slots
  logic                       slot_used_q   [NUM_TIMERS];
  logic [COUNT_W-1:0]         slot_period_q [NUM_TIMERS];
  logic signed [REMAIN_W-1:0] slot_remain_q [NUM_TIMERS];
  logic [KEY_W-1:0]           slot_key_q    [NUM_TIMERS];

  logic                       cur_used;
  logic [COUNT_W-1:0]         cur_period;
  logic signed [REMAIN_W-1:0] cur_remain;
  logic [KEY_W-1:0]           cur_key;

  logic                       wr_en;
  logic [SLOT_IDX_W-1:0]      wr_idx;
  logic                       wr_used;
  logic [COUNT_W-1:0]         wr_period;
  logic signed [REMAIN_W-1:0] wr_remain;
  logic [KEY_W-1:0]           wr_key;

  // Shared unit
  logic signed [REMAIN_W-1:0] unit_base;
  logic                       unit_reload_en;
  logic signed [REMAIN_W-1:0] unit_result;
  logic                       unit_le_zero;

  // Result path
  logic       accept;
  logic       emit_want;
  logic       finish_want;
  logic       room;
  logic       step_go;
  result_t    emit_res;
  buf_ctl_t   buf_ctl;
  buf_sts_t   buf_sts;
  result_t    out_res;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  assign cur_used   = slot_used_q[idx_q];
  assign cur_period = slot_period_q[idx_q];
  assign cur_remain = slot_remain_q[idx_q];
  assign cur_key    = slot_key_q[idx_q];

  // Shared unit operand select
  always_comb begin
    unit_reload_en = 1'b0;
    case (state_q)
      ST_HOLD_IRQ: unit_base = $signed(REMAIN_W'(irq_hold_q));
      ST_HOLD_NMI: unit_base = $signed(REMAIN_W'(nmi_hold_q));
      default: begin
        unit_base      = cur_remain;
        unit_reload_en = (state_q == ST_SLOT);
      end
    endcase
  end

  ctbh_step_unit u_step (
    .base_i      (unit_base),
    .reload_i    (cur_period),
    .reload_en_i (unit_reload_en),
    .elapsed_i   (elapsed_q),
    .result_o    (unit_result),
    .le_zero_o   (unit_le_zero)
  );

  // Sequencer next state and actions
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    irq_hold_d   = irq_hold_q;
    nmi_hold_d   = nmi_hold_q;
    irq_line_d   = irq_line_q;
    nmi_line_d   = nmi_line_q;
    emit_want    = 1'b0;
    finish_want  = 1'b0;
    emit_res.kind       = KIND_NOTHING;
    emit_res.fired_key  = '0;
    emit_res.set_ok     = 1'b0;
    emit_res.irq_active = irq_line_q;
    emit_res.nmi_active = nmi_line_q;
    wr_en     = 1'b0;
    wr_idx    = idx_q;
    wr_used   = cur_used;
    wr_period = cur_period;
    wr_remain = cur_remain;
    wr_key    = cur_key;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d = ST_DONE;
        case (op_q)
          OP_SET_TIMER: begin
            idx_d        = '0;
            free_found_d = 1'b0;
            state_d      = ST_FIND;
          end
          OP_ADVANCE: begin
            state_d = ST_HOLD_IRQ;
          end
          OP_ASSERT_IRQ: begin
            irq_hold_d    = cnt_q;
            irq_line_d    = 1'b1;
            emit_want     = 1'b1;
            emit_res.kind = KIND_ACK;
            emit_res.irq_active = 1'b1;
          end
          OP_ASSERT_NMI: begin
            nmi_hold_d    = cnt_q;
            nmi_line_d    = 1'b1;
            emit_want     = 1'b1;
            emit_res.kind = KIND_ACK;
            emit_res.nmi_active = 1'b1;
          end
          OP_CLEAR_IRQ: begin
            irq_hold_d    = '0;
            irq_line_d    = 1'b0;
            emit_want     = 1'b1;
            emit_res.kind = KIND_ACK;
            emit_res.irq_active = 1'b0;
          end
          OP_CLEAR_NMI: begin
            nmi_hold_d    = '0;
            nmi_line_d    = 1'b0;
            emit_want     = 1'b1;
            emit_res.kind = KIND_ACK;
            emit_res.nmi_active = 1'b0;
          end
          default: begin
            emit_want = 1'b1;
          end
        endcase
      end

      // Hold countdown; the line drops when the hold runs out
      ST_HOLD_IRQ: begin
        state_d = ST_HOLD_NMI;
        if (irq_hold_q != '0) begin
          if (unit_le_zero) begin
            irq_hold_d    = '0;
            irq_line_d    = 1'b0;
            emit_want     = 1'b1;
            emit_res.kind = KIND_IRQ_RELEASE;
            emit_res.irq_active = 1'b0;
          end else begin
            irq_hold_d = unit_result[COUNT_W-1:0];
          end
        end
      end

      ST_HOLD_NMI: begin
        state_d = ST_SLOT;
        idx_d   = '0;
        if (nmi_hold_q != '0) begin
          if (unit_le_zero) begin
            nmi_hold_d    = '0;
            nmi_line_d    = 1'b0;
            emit_want     = 1'b1;
            emit_res.kind = KIND_NMI_RELEASE;
            emit_res.nmi_active = 1'b0;
          end else begin
            nmi_hold_d = unit_result[COUNT_W-1:0];
          end
        end
      end

      // One slot per cycle through the shared unit, unless a step waits; only active timers are updated
      ST_SLOT: begin
        if (cur_used && (cur_period != '0)) begin
          wr_en     = 1'b1;
          wr_remain = unit_result;
          if (unit_le_zero) begin
            emit_want          = 1'b1;
            emit_res.kind      = KIND_FIRED;
            emit_res.fired_key = cur_key;
          end
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_IDX) begin
          state_d = ST_NOTHING;
        end
      end

      ST_NOTHING: begin
        state_d = ST_DONE;
        if (emit_cnt_q == '0) begin
          emit_want = 1'b1;
        end
      end

      // Key lookup; remember the first free slot on the way
      ST_FIND: begin
        if (cur_used && (cur_key == key_q)) begin
          wr_en           = 1'b1;
          wr_period       = cnt_q;
          wr_remain       = '0;
          wr_used         = (cnt_q != '0);
          emit_want       = 1'b1;
          emit_res.kind   = KIND_SET_REPLY;
          emit_res.set_ok = 1'b1;
          state_d         = ST_DONE;
        end else begin
          if (!cur_used && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
          idx_d = idx_q + 1'b1;
          if (idx_q == LAST_IDX) begin
            state_d = ST_CLAIM;
          end
        end
      end

      ST_CLAIM: begin
        state_d       = ST_DONE;
        emit_want     = 1'b1;
        emit_res.kind = KIND_SET_REPLY;
        if (free_found_q) begin
          wr_en           = 1'b1;
          wr_idx          = free_idx_q;
          wr_used         = 1'b1;
          wr_period       = cnt_q;
          wr_remain       = '0;
          wr_key          = key_q;
          emit_res.set_ok = 1'b1;
        end
      end

      ST_DONE: begin
        finish_want = 1'b1;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A step waits while the result buffer cannot take its result or finish
  assign room    = (emit_cnt_q < EMIT_CNT_W'(MAX_RESULTS));
  assign step_go = !(((emit_want && room) || finish_want) && !buf_sts.ready);

  assign buf_ctl.push   = emit_want && room && step_go;
  assign buf_ctl.finish = finish_want && step_go;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      irq_hold_q   <= '0;
      nmi_hold_q   <= '0;
      irq_line_q   <= 1'b0;
      nmi_line_q   <= 1'b0;
    end else if (step_go) begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      irq_hold_q   <= irq_hold_d;
      nmi_hold_q   <= nmi_hold_d;
      irq_line_q   <= irq_line_d;
      nmi_line_q   <= nmi_line_d;
    end
  end

  // Result count per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_cnt_q <= '0;
    end else if (accept) begin
      emit_cnt_q <= '0;
    end else if (buf_ctl.push) begin
      emit_cnt_q <= emit_cnt_q + 1'b1;
    end
  end

  // Latched transaction fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_i;
      key_q     <= timer_key_i;
      cnt_q     <= count_value_i;
      elapsed_q <= elapsed_cycles_i;
    end
  end

  // Slot storage, at most one write per cycle, held while a step waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        slot_used_q[i] <= 1'b0;
      end
    end else if (wr_en && step_go) begin
      slot_used_q[wr_idx] <= wr_used;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && step_go) begin
      slot_period_q[wr_idx] <= wr_period;
      slot_remain_q[wr_idx] <= wr_remain;
      slot_key_q[wr_idx]    <= wr_key;
    end
  end

  ctbh_result_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (buf_ctl),
    .res_i       (emit_res),
    .sts_o       (buf_sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res),
    .out_last_o  (last_o)
  );

  assign kind_o       = out_res.kind;
  assign fired_key_o  = out_res.fired_key;
  assign set_ok_o     = out_res.set_ok;
  assign irq_active_o = out_res.irq_active;
  assign nmi_active_o = out_res.nmi_active;

  // Checks
  a_emit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_cnt_q <= EMIT_CNT_W'(MAX_RESULTS))
    else $error("result count passed the per-transaction cap");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !buf_sts.pending)
    else $error("pending result left over when idle");

  a_done_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> buf_sts.pending)
    else $error("transaction ended without a result");

  a_irq_drop_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(irq_line_q) |-> ($past(state_q == ST_HOLD_IRQ) ||
                           ($past(state_q == ST_EXEC) && $past(op_q == OP_CLEAR_IRQ))))
    else $error("irq line dropped without release or clear");

endmodule
